>>> src/rsms_pkg.sv
// ----------------------------------------------------------------------------
// rsms_pkg: shared types and constants of the RNA structural motif scanner
// Sizes, field layouts, phrase kinds, register indexes and the base-pair test.
// ----------------------------------------------------------------------------
`default_nettype none

package rsms_pkg;

  localparam int MAX_PHRASES     = 16;
  localparam int MAX_WINDOW      = 32;
  localparam int POS_BITS        = 20;
  localparam int REACT_BITS      = 12;
  localparam int NUC_BITS        = 4;
  localparam int PCOUNT_BITS     = 5;
  localparam int MODE_BITS       = 2;
  localparam int KIND_BITS       = 2;
  localparam int WIN_IDX_BITS    = $clog2(MAX_WINDOW);
  localparam int LEN_BITS        = $clog2(MAX_WINDOW + 1);
  localparam int KINDS_BITS      = 32;
  localparam int MASKS_BITS      = 64;
  localparam int CFG_ADDR_BITS   = 3;
  localparam int CFG_DATA_BITS   = 64;

  // Stream payload widths, rounded up to whole bytes.
  localparam int S_TDATA_BITS = ((NUC_BITS + REACT_BITS + 7) / 8) * 8;
  localparam int S_TUSER_BITS = 1;
  localparam int M_TDATA_BITS = ((POS_BITS + 7) / 8) * 8;
  localparam int M_TUSER_BITS = 3;

  // One-hot nucleotide codes.
  localparam logic [NUC_BITS-1:0] NUC_A = 4'b0001;
  localparam logic [NUC_BITS-1:0] NUC_C = 4'b0010;
  localparam logic [NUC_BITS-1:0] NUC_G = 4'b0100;
  localparam logic [NUC_BITS-1:0] NUC_U = 4'b1000;

  // Match modes; the unused top code behaves as MODE_REACT.
  localparam logic [MODE_BITS-1:0] MODE_SEQ   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_PAIR  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_REACT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PCOUNT    = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_KINDS     = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MASKS     = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_THRESHOLD = 3'd4;

  localparam logic [REACT_BITS-1:0] THRESHOLD_RESET = 12'd512;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_PAIR    = 2'd0,
    KIND_LEFT    = 2'd1,
    KIND_RIGHT   = 2'd2,
    KIND_INVALID = 2'd3
  } kind_e;

  // One window position, held by one cell of the chain.
  typedef struct packed {
    logic                  missing;
    logic [REACT_BITS-1:0] reactivity;
    logic [NUC_BITS-1:0]   base;
  } win_entry_t;

  // Per-phrase settings, derived from the configuration registers.
  typedef struct packed {
    logic                    used;
    kind_e                   kind;
    logic [NUC_BITS-1:0]     mask;
    logic [WIN_IDX_BITS-1:0] lidx;
    logic [WIN_IDX_BITS-1:0] ridx;
  } phrase_cfg_t;

  // Settings shared by every phrase checker.
  typedef struct packed {
    logic                  pairing;
    logic                  react;
    logic [REACT_BITS-1:0] threshold;
  } check_ctrl_t;

  // Result item as it waits in the output register or the skid stage.
  typedef struct packed {
    logic                last;
    logic                first;
    logic                hit;
    logic                ready;
    logic [POS_BITS-1:0] start;
  } out_item_t;

  // Watson-Crick and G-U wobble pairs.
  function automatic logic can_pair(logic [NUC_BITS-1:0] a, logic [NUC_BITS-1:0] b);
    return (a == NUC_U && b == NUC_A) || (a == NUC_C && b == NUC_G) ||
           (a == NUC_G && b == NUC_C) || (a == NUC_A && b == NUC_U) ||
           (a == NUC_U && b == NUC_G) || (a == NUC_G && b == NUC_U);
  endfunction

  // Bits below position n set, the rest clear.
  function automatic logic [MAX_PHRASES-1:0] low_bits(int n);
    logic [MAX_PHRASES-1:0] m;
    for (int j = 0; j < MAX_PHRASES; j++) begin
      m[j] = (j < n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> src/rsms_cell.sv
// ----------------------------------------------------------------------------
// rsms_cell: one position of the base window
// Holds one base with its reactivity and hands it to the next cell on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rsms_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                shift_i,
  input  wire rsms_pkg::win_entry_t entry_i,
  output rsms_pkg::win_entry_t     entry_o
);

  rsms_pkg::win_entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

>>> src/rsms_phrase_check.sv
// ----------------------------------------------------------------------------
// rsms_phrase_check: test of one motif phrase against the window
// Picks the left and right bases of the phrase and applies the mask, pairing
// and reactivity tests for its kind.
// ----------------------------------------------------------------------------
`default_nettype none

module rsms_phrase_check (
  input  wire rsms_pkg::win_entry_t  win_i [rsms_pkg::MAX_WINDOW],
  input  wire rsms_pkg::phrase_cfg_t cfg_i,
  input  wire rsms_pkg::check_ctrl_t ctrl_i,
  output logic                       pass_o
);

  rsms_pkg::win_entry_t lb;
  rsms_pkg::win_entry_t rb;
  logic l_mask_ok, r_mask_ok;
  logic l_low, l_high, r_low, r_high;
  logic ok;

  assign lb = win_i[cfg_i.lidx];
  assign rb = win_i[cfg_i.ridx];

  assign l_mask_ok = (lb.base & cfg_i.mask) == lb.base;
  assign r_mask_ok = (rb.base & cfg_i.mask) == rb.base;

  // A missing reactivity passes either way.
  assign l_low  = lb.missing || (lb.reactivity <= ctrl_i.threshold);
  assign l_high = lb.missing || (lb.reactivity >= ctrl_i.threshold);
  assign r_low  = rb.missing || (rb.reactivity <= ctrl_i.threshold);
  assign r_high = rb.missing || (rb.reactivity >= ctrl_i.threshold);

  always_comb begin
    unique case (cfg_i.kind)
      rsms_pkg::KIND_PAIR: begin
        ok = l_mask_ok &&
             (!ctrl_i.pairing || rsms_pkg::can_pair(lb.base, rb.base)) &&
             (!ctrl_i.react || (l_low && r_low));
      end
      rsms_pkg::KIND_LEFT: begin
        ok = l_mask_ok && (!ctrl_i.react || l_high);
      end
      rsms_pkg::KIND_RIGHT: begin
        ok = r_mask_ok && (!ctrl_i.react || r_high);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign pass_o = !cfg_i.used || ok;

endmodule

`default_nettype wire

>>> src/rna_structural_motif_scanner.sv
// ----------------------------------------------------------------------------
// rna_structural_motif_scanner: stem-loop motif scan over a stream of bases
// Slides a window over the bases and reports motif hits with their starts.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one base per transfer: tdata holds the one-hot
//   nucleotide and its Q2.10 reactivity, tuser the missing flag and tlast
//   the last base of a sequence. The master stream returns one result per
//   base: window ready, hit and first hit in tuser, the start offset in
//   tdata and the end marker in tlast. Configuration registers are written
//   through the cfg channel, which is always ready; the user must write them
//   only while the block is idle, which the block itself does not enforce.
//   One base is taken every cycle while s_axis_tready is high. A base passes
//   through the chain of window cells, which shifts once per transfer, then
//   one gather and check stage and one result stage.
//   When the receiver stalls, an output register and a skid stage absorb the
//   results in flight; s_axis_tready falls only once the skid stage is full.
//   Reset clears the window, the base count, the hit flag and the pipeline,
//   and loads the register defaults (mode 2, one pair phrase, threshold 0.5).
// ----------------------------------------------------------------------------
`default_nettype none

module rna_structural_motif_scanner (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [3:0] nucleotide, [15:4] reactivity
  input  wire logic [rsms_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
  // [0] reactivity_missing
  input  wire logic [rsms_pkg::S_TUSER_BITS-1:0]    s_axis_tuser,
  input  wire logic                                 s_axis_tlast,
  // Result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [19:0] start_position, [23:20] zero
  output logic [rsms_pkg::M_TDATA_BITS-1:0]         m_axis_tdata,
  // [0] window_ready, [1] hit, [2] first_hit
  output logic [rsms_pkg::M_TUSER_BITS-1:0]         m_axis_tuser,
  output logic                                      m_axis_tlast,
  // Configuration writes
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [rsms_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  wire logic [rsms_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i
);

  localparam int NPH  = rsms_pkg::MAX_PHRASES;
  localparam int NWIN = rsms_pkg::MAX_WINDOW;

  // ---------------------------------------------------------------- config
  logic [rsms_pkg::MODE_BITS-1:0]   mode_q;
  logic [rsms_pkg::PCOUNT_BITS-1:0] pcount_q;
  logic [rsms_pkg::KINDS_BITS-1:0]  kinds_q;
  logic [rsms_pkg::MASKS_BITS-1:0]  masks_q;
  logic [rsms_pkg::REACT_BITS-1:0]  thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rsms_pkg::MODE_REACT;
      pcount_q <= rsms_pkg::PCOUNT_BITS'(1);
      kinds_q  <= '0;
      masks_q  <= '0;
      thr_q    <= rsms_pkg::THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        rsms_pkg::REG_MODE:      mode_q   <= cfg_wdata_i[rsms_pkg::MODE_BITS-1:0];
        rsms_pkg::REG_PCOUNT:    pcount_q <= cfg_wdata_i[rsms_pkg::PCOUNT_BITS-1:0];
        rsms_pkg::REG_KINDS:     kinds_q  <= cfg_wdata_i[rsms_pkg::KINDS_BITS-1:0];
        rsms_pkg::REG_MASKS:     masks_q  <= cfg_wdata_i[rsms_pkg::MASKS_BITS-1:0];
        rsms_pkg::REG_THRESHOLD: thr_q    <= cfg_wdata_i[rsms_pkg::REACT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Phrase positions follow from the registers alone, so they are worked out
  // once per cycle and registered ahead of their first use.
  logic [rsms_pkg::PCOUNT_BITS-1:0] n_used;
  logic [NPH-1:0]                   used, pair_use, left_use, right_use;
  logic [rsms_pkg::LEN_BITS-1:0]    len_d, len_q;
  rsms_pkg::phrase_cfg_t            phr_d [NPH];
  rsms_pkg::phrase_cfg_t            phr_q [NPH];

  assign n_used = (pcount_q > rsms_pkg::PCOUNT_BITS'(NPH)) ?
                  rsms_pkg::PCOUNT_BITS'(NPH) : pcount_q;

  for (genvar i = 0; i < NPH; i++) begin : g_use
    rsms_pkg::kind_e kind;
    assign kind         = rsms_pkg::kind_e'(kinds_q[2*i +: 2]);
    assign used[i]      = rsms_pkg::PCOUNT_BITS'(i) < n_used;
    assign pair_use[i]  = used[i] && (kind == rsms_pkg::KIND_PAIR);
    assign left_use[i]  = used[i] && ((kind == rsms_pkg::KIND_PAIR) ||
                                      (kind == rsms_pkg::KIND_LEFT));
    assign right_use[i] = used[i] && ((kind == rsms_pkg::KIND_PAIR) ||
                                      (kind == rsms_pkg::KIND_RIGHT));
  end

  // Pair phrases take two bases, all others one.
  assign len_d = rsms_pkg::LEN_BITS'(n_used) + rsms_pkg::LEN_BITS'($countones(pair_use));

  for (genvar i = 0; i < NPH; i++) begin : g_phr
    logic [rsms_pkg::LEN_BITS-1:0] lcnt, rcnt, lpos;
    assign lcnt = rsms_pkg::LEN_BITS'($countones(left_use & rsms_pkg::low_bits(i)));
    assign rcnt = rsms_pkg::LEN_BITS'($countones(right_use & rsms_pkg::low_bits(i)));
    // Window index 0 is the newest base; the window start sits at len - 1.
    assign lpos = len_d - rsms_pkg::LEN_BITS'(1) - lcnt;
    assign phr_d[i].used = used[i];
    assign phr_d[i].kind = rsms_pkg::kind_e'(kinds_q[2*i +: 2]);
    assign phr_d[i].mask = masks_q[4*i +: 4];
    assign phr_d[i].lidx = lpos[rsms_pkg::WIN_IDX_BITS-1:0];
    assign phr_d[i].ridx = rcnt[rsms_pkg::WIN_IDX_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    phr_q <= phr_d;
  end

  rsms_pkg::check_ctrl_t ctrl;
  assign ctrl.pairing   = mode_q != rsms_pkg::MODE_SEQ;
  assign ctrl.react     = mode_q >= rsms_pkg::MODE_REACT;
  assign ctrl.threshold = thr_q;

  // ------------------------------------------------------------- handshake
  logic vo_q, vs_q, v1_q, v2_q;
  logic en, s_fire, out_fire, push;

  assign en            = !vs_q;
  assign s_axis_tready = en;
  assign s_fire        = s_axis_tvalid && en;
  assign out_fire      = vo_q && m_axis_tready;
  assign push          = v2_q && en;

  // ---------------------------------------------------------- window chain
  rsms_pkg::win_entry_t new_entry;
  rsms_pkg::win_entry_t win [NWIN];

  assign new_entry.base       = s_axis_tdata[rsms_pkg::NUC_BITS-1:0];
  assign new_entry.reactivity =
    s_axis_tdata[rsms_pkg::NUC_BITS +: rsms_pkg::REACT_BITS];
  assign new_entry.missing    = s_axis_tuser[0];

  for (genvar k = 0; k < NWIN; k++) begin : g_cell
    rsms_pkg::win_entry_t cell_in;
    if (k == 0) begin : g_head
      assign cell_in = new_entry;
    end else begin : g_body
      assign cell_in = win[k-1];
    end
    rsms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s_fire),
      .entry_i (cell_in),
      .entry_o (win[k])
    );
  end

  // --------------------------------------------------------- phrase checks
  logic [NPH-1:0] pass;

  for (genvar i = 0; i < NPH; i++) begin : g_chk
    rsms_phrase_check u_chk (
      .win_i  (win),
      .cfg_i  (phr_q[i]),
      .ctrl_i (ctrl),
      .pass_o (pass[i])
    );
  end

  // ------------------------------------------------------ count and stages
  logic [rsms_pkg::POS_BITS-1:0] base_count_q, count_next;
  logic [rsms_pkg::POS_BITS-1:0] cnt1_q, cnt2_q;
  logic                          last1_q, last2_q;
  logic [NPH-1:0]                pass_q;
  logic                          hit_seen_q;

  // The count saturates on very long sequences.
  assign count_next = (base_count_q == '1) ? base_count_q :
                      base_count_q + rsms_pkg::POS_BITS'(1);

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cnt1_q  <= count_next;
      last1_q <= s_axis_tlast;
    end
    // The window still holds the stage-one item while it is gathered.
    if (en && v1_q) begin
      pass_q  <= pass;
      cnt2_q  <= cnt1_q;
      last2_q <= last1_q;
    end
  end

  rsms_pkg::out_item_t res, out_q, skid_q;
  logic                len_ok;

  assign len_ok    = (len_q != '0) && (cnt2_q >= rsms_pkg::POS_BITS'(len_q));
  assign res.ready = len_ok;
  assign res.hit   = len_ok && (&pass_q);
  assign res.first = len_ok && (&pass_q) && !hit_seen_q;
  assign res.start = len_ok ? cnt2_q - rsms_pkg::POS_BITS'(len_q) : '0;
  assign res.last  = last2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_count_q <= '0;
      hit_seen_q   <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      vo_q         <= 1'b0;
      vs_q         <= 1'b0;
    end else begin
      if (en) begin
        v1_q <= s_fire;
        v2_q <= v1_q;
      end
      if (s_fire) begin
        base_count_q <= s_axis_tlast ? '0 : count_next;
      end
      if (push) begin
        hit_seen_q <= last2_q ? 1'b0 : (hit_seen_q || res.hit);
      end
      if (vs_q) begin
        if (out_fire) begin
          vs_q <= 1'b0;
        end
      end else if (push) begin
        vo_q <= 1'b1;
        if (vo_q && !out_fire) begin
          vs_q <= 1'b1;
        end
      end else if (out_fire) begin
        vo_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vs_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!vo_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = rsms_pkg::M_TDATA_BITS'(out_q.start);
  assign m_axis_tuser  = {out_q.first, out_q.hit, out_q.ready};
  assign m_axis_tlast  = out_q.last;

  // ------------------------------------------------------------ assertions
  // The skid stage only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vs_q |-> vo_q)
    else $error("skid stage holds a result while the output register is empty");

  // The input side stalls only while a result waits on the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // A first hit is a hit, and a hit needs a full window.
  a_hit_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((!m_axis_tuser[2] || m_axis_tuser[1]) &&
                       (!m_axis_tuser[1] || m_axis_tuser[0])))
    else $error("first_hit or hit without its precondition");

  // A stage-two item moves on in the next cycle unless the skid stage is full.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !vs_q) |=> (vo_q && ($past(vo_q) ? ($past(out_fire) || vs_q) : 1'b1)))
    else $error("result lost between the check stage and the output");

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RNA structural motif scanner
// Streams bases through the slave port while both stream sides idle in random
// bursts. Every accepted base runs through a local scan model, and every
// result transfer is checked field by field against the oldest prediction.
// Directed windows come first, then random configurations with mostly
// well-formed stem-loop windows, and a closing stretch without idling.
// ----------------------------------------------------------------------------

module tb_top;
  import rsms_pkg::*;

  // The top mode code is decoded like the reactivity mode.
  localparam logic [MODE_BITS-1:0] MODE_REACT_ALT = 2'd3;
  localparam int RANDOM_BASES = 1170;

  typedef struct packed {
    logic                  last;
    logic                  miss;
    logic [REACT_BITS-1:0] react;
    logic [NUC_BITS-1:0]   nuc;
  } base_item_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [S_TDATA_BITS-1:0] s_axis_tdata;
  logic [S_TUSER_BITS-1:0] s_axis_tuser;
  logic                    s_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [M_TDATA_BITS-1:0] m_axis_tdata;
  logic [M_TUSER_BITS-1:0] m_axis_tuser;
  logic                    m_axis_tlast;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  rna_structural_motif_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  base_item_t base_q[$];
  out_item_t  scan_q[$];

  // Configuration as last written.
  logic [MODE_BITS-1:0]   cur_mode   = MODE_REACT;
  logic [PCOUNT_BITS-1:0] cur_count  = PCOUNT_BITS'(1);
  logic [KINDS_BITS-1:0]  cur_kinds  = '0;
  logic [MASKS_BITS-1:0]  cur_masks  = '0;
  logic [REACT_BITS-1:0]  cur_thresh = THRESHOLD_RESET;

  // Scan state: a circular window, newest base at win_head.
  logic [NUC_BITS-1:0]     win_nuc   [MAX_WINDOW];
  logic [REACT_BITS-1:0]   win_react [MAX_WINDOW];
  logic                    win_miss  [MAX_WINDOW];
  logic [WIN_IDX_BITS-1:0] win_head   = '0;
  logic [POS_BITS-1:0]     seq_count  = '0;
  logic                    hit_in_seq = 1'b0;

  bit in_took = 1'b0;
  int src_gap = 0, snk_gap = 0;
  int src_idle_pct = 0, snk_idle_pct = 0;
  int errors = 0, n_pushed = 0, n_results = 0, n_ready = 0, n_hits = 0, n_firsts = 0;
  int n_configs = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("** rna_structural_motif_scanner: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- model --

  function automatic int used_phrases();
    return (cur_count > MAX_PHRASES) ? MAX_PHRASES : int'(cur_count);
  endfunction

  function automatic kind_e phrase_kind(int i);
    return kind_e'(cur_kinds[KIND_BITS*i +: KIND_BITS]);
  endfunction

  function automatic logic [NUC_BITS-1:0] phrase_mask(int i);
    return cur_masks[NUC_BITS*i +: NUC_BITS];
  endfunction

  function automatic int motif_length();
    int len, i;
    len = 0;
    for (i = 0; i < used_phrases(); i++) len += (phrase_kind(i) == KIND_PAIR) ? 2 : 1;
    return len;
  endfunction

  function automatic bit fits(logic [NUC_BITS-1:0] b, logic [NUC_BITS-1:0] m);
    return (b & ~m) == '0;
  endfunction

  function automatic bit pairs_with(logic [NUC_BITS-1:0] a, logic [NUC_BITS-1:0] b);
    case ({a, b})
      {NUC_A, NUC_U}, {NUC_U, NUC_A}, {NUC_C, NUC_G},
      {NUC_G, NUC_C}, {NUC_G, NUC_U}, {NUC_U, NUC_G}: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Slot of the base k places back from the newest one.
  function automatic int slot(int k);
    return (int'(win_head) - k) & (MAX_WINDOW - 1);
  endfunction

  // Phrases are checked from the outside in; offset 0 is the oldest base.
  function automatic bit window_hit(int len);
    int i, lo, hi, ls, rs;
    bit pairing, react;
    logic [NUC_BITS-1:0] m;
    lo = 0;
    hi = len - 1;
    pairing = cur_mode >= MODE_PAIR;
    react = cur_mode >= MODE_REACT;
    for (i = 0; i < used_phrases(); i++) begin
      m = phrase_mask(i);
      ls = slot(len - 1 - lo);
      rs = slot(len - 1 - hi);
      case (phrase_kind(i))
        KIND_PAIR: begin
          if (!fits(win_nuc[ls], m)) return 1'b0;
          if (pairing && !pairs_with(win_nuc[ls], win_nuc[rs])) return 1'b0;
          if (react && !win_miss[ls] && win_react[ls] > cur_thresh) return 1'b0;
          if (react && !win_miss[rs] && win_react[rs] > cur_thresh) return 1'b0;
          lo++;
          hi--;
        end
        KIND_LEFT: begin
          if (!fits(win_nuc[ls], m)) return 1'b0;
          if (react && !win_miss[ls] && win_react[ls] < cur_thresh) return 1'b0;
          lo++;
        end
        KIND_RIGHT: begin
          if (!fits(win_nuc[rs], m)) return 1'b0;
          if (react && !win_miss[rs] && win_react[rs] < cur_thresh) return 1'b0;
          hi--;
        end
        default: return 1'b0;
      endcase
    end
    return 1'b1;
  endfunction

  function automatic out_item_t scan_base(base_item_t b);
    out_item_t r;
    int len;
    len = motif_length();
    win_head = win_head + 1'b1;
    win_nuc[win_head] = b.nuc;
    win_react[win_head] = b.react;
    win_miss[win_head] = b.miss;
    if (seq_count != '1) seq_count = seq_count + 1'b1;
    r = '0;
    r.last = b.last;
    if (len >= 1 && len <= MAX_WINDOW && seq_count >= len) begin
      r.ready = 1'b1;
      r.start = POS_BITS'(seq_count - len);
      r.hit = window_hit(len);
      r.first = r.hit && !hit_in_seq;
      if (r.hit) hit_in_seq = 1'b1;
    end
    if (b.last) begin
      seq_count = '0;
      hit_in_seq = 1'b0;
    end
    return r;
  endfunction

  // -------------------------------------------------------- driver, monitor --

  always @(negedge clk_i) begin
    // A presented base stays on the bus until its transfer.
    if (!(s_axis_tvalid && !in_took)) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (base_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
        src_gap = $urandom_range(0, 9);
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {base_q[0].react, base_q[0].nuc};
        s_axis_tuser  <= base_q[0].miss;
        s_axis_tlast  <= base_q[0].last;
      end
    end
    if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else if (snk_idle_pct != 0 && $urandom_range(1, 100) <= snk_idle_pct) begin
      snk_gap = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_item_t got, want;
    base_item_t b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.start = m_axis_tdata[POS_BITS-1:0];
      got.ready = m_axis_tuser[0];
      got.hit   = m_axis_tuser[1];
      got.first = m_axis_tuser[2];
      got.last  = m_axis_tlast;
      n_results++;
      n_ready += got.ready;
      n_hits += got.hit;
      n_firsts += got.first;
      if (scan_q.size() == 0) begin
        $error("result transfer with no base pending: start %0d, flags %b",
               got.start, m_axis_tuser);
        errors++;
      end else begin
        want = scan_q.pop_front();
        check_field("window_ready", want.ready, got.ready);
        check_field("hit", want.hit, got.hit);
        check_field("first_hit", want.first, got.first);
        check_field("start_position", want.start, got.start);
        check_field("end_marker", want.last, got.last);
      end
    end
    in_took = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_took) begin
      b.nuc   = s_axis_tdata[NUC_BITS-1:0];
      b.react = s_axis_tdata[NUC_BITS +: REACT_BITS];
      b.miss  = s_axis_tuser[0];
      b.last  = s_axis_tlast;
      scan_q.push_back(scan_base(b));
      void'(base_q.pop_front());
    end
  end

  // -------------------------------------------------------------- stimulus --

  function automatic base_item_t make_base(logic [NUC_BITS-1:0] nuc,
                                           logic [REACT_BITS-1:0] react,
                                           logic miss, logic last);
    base_item_t b;
    b.nuc = nuc;
    b.react = react;
    b.miss = miss;
    b.last = last;
    return b;
  endfunction

  function automatic base_item_t noise_base();
    int sel;
    logic [REACT_BITS-1:0] r;
    sel = $urandom_range(0, 7);
    r = (sel == 0) ? '0 : (sel == 1) ? '1 : REACT_BITS'($urandom_range(0, 4095));
    return make_base(NUC_BITS'($urandom_range(0, 15)), r, $urandom_range(0, 7) == 0, 1'b0);
  endfunction

  function automatic logic [NUC_BITS-1:0] pick_base(logic [NUC_BITS-1:0] m);
    logic [NUC_BITS-1:0] b;
    if (m == '0) return '0;
    // A multi-bit subset of the mask also passes the base test.
    if ($urandom_range(0, 3) == 0) return m;
    do b = NUC_BITS'(1 << $urandom_range(0, 3)); while ((b & m) == '0);
    return b;
  endfunction

  function automatic logic [NUC_BITS-1:0] partner(logic [NUC_BITS-1:0] b);
    case (b)
      NUC_A: return NUC_U;
      NUC_C: return NUC_G;
      NUC_G: return $urandom_range(0, 1) ? NUC_C : NUC_U;
      NUC_U: return $urandom_range(0, 1) ? NUC_A : NUC_G;
      default: return NUC_BITS'($urandom_range(0, 15));
    endcase
  endfunction

  // Paired bases sit at or below the threshold, bulged ones at or above it.
  function automatic base_item_t stem_base(logic [NUC_BITS-1:0] nuc);
    if ($urandom_range(0, 5) == 0)
      return make_base(nuc, REACT_BITS'($urandom_range(0, 4095)), 1'b1, 1'b0);
    return make_base(nuc, REACT_BITS'($urandom_range(0, cur_thresh)), 1'b0, 1'b0);
  endfunction

  function automatic base_item_t loop_base(logic [NUC_BITS-1:0] nuc);
    if ($urandom_range(0, 5) == 0)
      return make_base(nuc, REACT_BITS'($urandom_range(0, 4095)), 1'b1, 1'b0);
    return make_base(nuc, REACT_BITS'($urandom_range(cur_thresh, 4095)), 1'b0, 1'b0);
  endfunction

  task automatic push_base(base_item_t b);
    base_q.push_back(b);
    n_pushed++;
  endtask

  // Builds a window that the current motif accepts, optionally spoiled.
  task automatic push_motif(bit spoil, bit close);
    base_item_t m [MAX_WINDOW];
    logic [NUC_BITS-1:0] lb;
    int len, lo, hi, k;
    len = motif_length();
    lo = 0;
    hi = len - 1;
    for (k = 0; k < MAX_WINDOW; k++) m[k] = noise_base();
    for (k = 0; k < used_phrases(); k++) begin
      case (phrase_kind(k))
        KIND_PAIR: begin
          lb = pick_base(phrase_mask(k));
          m[lo] = stem_base(lb);
          m[hi] = stem_base(partner(lb));
          lo++;
          hi--;
        end
        KIND_LEFT: begin
          m[lo] = loop_base(pick_base(phrase_mask(k)));
          lo++;
        end
        KIND_RIGHT: begin
          m[hi] = loop_base(pick_base(phrase_mask(k)));
          hi--;
        end
        default: lo++;
      endcase
    end
    if (spoil) m[$urandom_range(0, len - 1)] = noise_base();
    for (k = 0; k < len; k++) begin
      m[k].last = close && (k == len - 1);
      push_base(m[k]);
    end
  endtask

  task automatic wait_drained();
    while (base_q.size() != 0 || scan_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:      cur_mode   = value[MODE_BITS-1:0];
      REG_PCOUNT:    cur_count  = value[PCOUNT_BITS-1:0];
      REG_KINDS:     cur_kinds  = value[KINDS_BITS-1:0];
      REG_MASKS:     cur_masks  = value[MASKS_BITS-1:0];
      REG_THRESHOLD: cur_thresh = value[REACT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_config(logic [MODE_BITS-1:0] mode, logic [PCOUNT_BITS-1:0] count,
                              logic [KINDS_BITS-1:0] kinds, logic [MASKS_BITS-1:0] masks,
                              logic [REACT_BITS-1:0] thr);
    wait_drained();
    write_reg(REG_MODE, CFG_DATA_BITS'(mode));
    write_reg(REG_PCOUNT, CFG_DATA_BITS'(count));
    write_reg(REG_KINDS, CFG_DATA_BITS'(kinds));
    write_reg(REG_MASKS, masks);
    write_reg(REG_THRESHOLD, CFG_DATA_BITS'(thr));
    n_configs++;
  endtask

  task automatic random_phase(int idx, int n_items, bit idling);
    logic [MODE_BITS-1:0]   mode;
    logic [PCOUNT_BITS-1:0] count;
    logic [KINDS_BITS-1:0]  kinds;
    logic [MASKS_BITS-1:0]  masks;
    logic [REACT_BITS-1:0]  thr;
    int sel, k, first_item;
    mode = MODE_BITS'($urandom_range(0, 3));
    sel = $urandom_range(0, 9);
    count = (sel == 0) ? PCOUNT_BITS'($urandom_range(17, 31)) :
            (sel < 6)  ? PCOUNT_BITS'($urandom_range(1, 3)) :
                         PCOUNT_BITS'($urandom_range(4, 10));
    for (k = 0; k < MAX_PHRASES; k++) begin
      sel = $urandom_range(0, 19);
      kinds[KIND_BITS*k +: KIND_BITS] = (sel == 0) ? KIND_INVALID : kind_e'(sel % 3);
      sel = $urandom_range(0, 5);
      masks[NUC_BITS*k +: NUC_BITS] = (sel == 0) ? 4'hF : NUC_BITS'($urandom_range(1, 15));
    end
    sel = $urandom_range(0, 9);
    thr = (sel == 0) ? '0 : (sel == 1) ? '1 : REACT_BITS'($urandom_range(0, 4095));
    case (idx)
      0: begin
        thr = '0;
        masks = '1;
      end
      1: begin
        thr = '1;
        count = '1;
      end
      2: begin
        // Sixteen stems fill the whole window.
        mode = MODE_PAIR;
        count = PCOUNT_BITS'(MAX_PHRASES);
        kinds = {MAX_PHRASES{KIND_PAIR}};
        masks = '1;
      end
      3: count = '0;
      4: begin
        mode = MODE_SEQ;
        masks = '0;
      end
      5: kinds = {MAX_PHRASES{KIND_INVALID}};
      6: kinds = $urandom;
      default: ;
    endcase
    apply_config(mode, count, kinds, masks, thr);
    src_idle_pct = idling ? 20 * $urandom_range(0, 2) : 0;
    snk_idle_pct = idling ? 20 * $urandom_range(0, 2) : 0;
    first_item = n_pushed;
    while (n_pushed - first_item < n_items) begin
      sel = $urandom_range(0, 9);
      if (sel < 7 && motif_length() > 0) begin
        repeat ($urandom_range(0, 3)) push_base(noise_base());
        push_motif($urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
      end else if (sel < 9) begin
        repeat ($urandom_range(1, 8)) begin
          base_item_t b;
          b = noise_base();
          b.last = $urandom_range(0, 7) == 0;
          push_base(b);
        end
      end else begin
        base_item_t b;
        b = noise_base();
        b.last = 1'b1;
        push_base(b);
      end
    end
  endtask

  initial begin
    int idx, k;
    for (k = 0; k < MAX_WINDOW; k++) begin
      win_nuc[k] = '0;
      win_react[k] = '0;
      win_miss[k] = 1'b0;
    end
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: one stem with an empty mask, so only base 0 fits.
    push_base(make_base('0, '0, 1'b0, 1'b0));
    push_base(make_base('0, '1, 1'b1, 1'b0));
    push_base(make_base(4'hF, '1, 1'b0, 1'b1));

    // Stem, left bulge and right bulge; hits twice in one sequence.
    apply_config(MODE_PAIR, PCOUNT_BITS'(3), KINDS_BITS'({KIND_RIGHT, KIND_LEFT, KIND_PAIR}),
                 MASKS_BITS'({NUC_U, NUC_A, NUC_G}), THRESHOLD_RESET);
    push_base(make_base(NUC_G, '0, 1'b0, 1'b0));
    push_base(make_base(NUC_A, '1, 1'b0, 1'b0));
    push_base(make_base(NUC_U, '0, 1'b1, 1'b0));
    push_base(make_base(NUC_C, '1, 1'b0, 1'b0));
    push_base(make_base(NUC_G, '0, 1'b0, 1'b0));
    push_base(make_base(NUC_A, '0, 1'b0, 1'b0));
    push_base(make_base(NUC_U, '0, 1'b0, 1'b0));
    push_base(make_base(NUC_U, '0, 1'b0, 1'b1));

    // Reactivity on the threshold passes; one step above the stem limit fails.
    apply_config(MODE_REACT, PCOUNT_BITS'(2), KINDS_BITS'({KIND_LEFT, KIND_PAIR}), 64'hFF,
                 12'd2048);
    push_base(make_base(NUC_A, 12'd2048, 1'b0, 1'b0));
    push_base(make_base(NUC_C, 12'd2048, 1'b0, 1'b0));
    push_base(make_base(NUC_U, '1, 1'b1, 1'b1));
    push_base(make_base(NUC_A, 12'd2049, 1'b0, 1'b0));
    push_base(make_base(NUC_C, '0, 1'b1, 1'b0));
    push_base(make_base(NUC_U, '0, 1'b0, 1'b1));

    // Top mode code with an invalid phrase behind a good stem.
    apply_config(MODE_REACT_ALT, PCOUNT_BITS'(2), KINDS_BITS'({KIND_INVALID, KIND_PAIR}),
                 64'hFF, 12'd2048);
    push_base(make_base(NUC_G, '0, 1'b0, 1'b0));
    push_base(make_base(NUC_C, '0, 1'b0, 1'b0));
    push_base(make_base(NUC_U, '0, 1'b0, 1'b1));

    // No phrases: windows are never ready.
    apply_config(MODE_SEQ, '0, '0, '1, THRESHOLD_RESET);
    push_base(make_base(NUC_A, '0, 1'b0, 1'b0));
    push_base(make_base(NUC_C, '0, 1'b0, 1'b1));

    idx = 0;
    while (n_pushed < RANDOM_BASES) begin
      random_phase(idx, $urandom_range(60, 140), 1'b1);
      idx++;
    end

    random_phase(idx + 1, 150, 1'b0);

    k = 0;
    while ((base_q.size() != 0 || scan_q.size() != 0) && k < 5000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (10) @(posedge clk_i);
    if (scan_q.size() != 0) begin
      $error("%0d predicted results never arrived", scan_q.size());
      errors++;
    end

    $display("Checked %0d results of %0d bases under %0d settings: %0d ready windows,",
             n_results, n_pushed, n_configs, n_ready);
    $display("%0d hits and %0d first hits, with random stalls on both stream sides.",
             n_hits, n_firsts);
    if (errors == 0) begin
      $display("** rna_structural_motif_scanner: PASSED **");
    end else begin
      $display("** rna_structural_motif_scanner: FAILED **");
    end
    $finish;
  end

endmodule
